// ===== design/slit_pkg.sv =====
// ----------------------------------------------------------------------------
// slit_pkg: shared types and constants for the speed limit interval table
// Sizes, request codes, controller states and the ctrl/datapath bundles.
// ----------------------------------------------------------------------------
package slit_pkg;

	localparam int MaxIntervals = 32;
	localparam int IdxW = $clog2(MaxIntervals);
	localparam int CntW = $clog2(MaxIntervals + 1);
	localparam int PieceCap = 3 * MaxIntervals + 1;
	localparam int PcW = $clog2(PieceCap + 1);
	localparam int PosW = 32;
	localparam int LimW = 16;
	localparam int OutCntW = 6;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_WALK,
		ST_TAIL,
		ST_SORT,
		ST_COPY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;      // latch request fields
		logic look_step; // examine entry idx
		logic walk_step; // split entry idx into pieces
		logic tail;      // emit final new-range piece
		logic sort_step; // one insertion-sort step
		logic copy_step; // write scratch back to table
		logic commit;    // set count from piece count
		logic fin;       // latch the result word
	} cmd_t;

	typedef struct packed {
		logic req_type;
		logic idx_last;   // idx reached count
		logic look_hit;
		logic sort_done;
		logic copy_done;
		logic over;       // pieces exceed capacity
	} sts_t;

endpackage

// ===== design/slit_if.sv =====
// ----------------------------------------------------------------------------
// slit_req_if / slit_rsp_if: valid/ready channels of the interval table
// Request and result words with source and sink modports.
// ----------------------------------------------------------------------------
interface slit_req_if;
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic signed [31:0]   start_pos;
	logic signed [31:0]   end_pos;
	logic        [15:0]   limit_value;
	logic signed [31:0]   query_pos;
	modport source (output valid, req_type, start_pos, end_pos, limit_value, query_pos,
		input ready);
	modport sink (input valid, req_type, start_pos, end_pos, limit_value, query_pos,
		output ready);
endinterface

interface slit_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] limit_out;
	logic        overflow;
	logic [5:0]  entry_count;
	modport source (output valid, found, limit_out, overflow, entry_count, input ready);
	modport sink (input valid, found, limit_out, overflow, entry_count, output ready);
endinterface

// ===== design/speed_limit_interval_table.sv =====
// ----------------------------------------------------------------------------
// speed_limit_interval_table: sorted speed limit interval store
// Inserts merge a limit interval into the table; lookups return a limit.
// ----------------------------------------------------------------------------
// channel | dir | word
// req     | in  | req_type, start_pos, end_pos, limit_value, query_pos
// rsp     | out | found, limit_out, overflow, entry_count
//
// Lookup: scans the n stored entries, one entry per cycle, until a hit or the end.
// Insert: walks the n entries one per cycle, adds the final new-range piece,
// then sorts the p pieces and copies them back; a rejected insert skips both.
// The single-step sort over the scratch pieces sets the insert time.
// Reset empties the table at once; the result register frees the input
// while a word waits on rsp, and a finished word waits until rsp is free.
module speed_limit_interval_table (
	input logic       clk,
	input logic       arst_n,
	slit_req_if.sink  req,
	slit_rsp_if.source rsp
);
	import slit_pkg::*;

	cmd_t cmd;
	sts_t sts;

	slit_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (req.valid), .in_ready (req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts, .cmd
	);

	slit_dp u_dp (
		.clk, .arst_n,
		.req_type(req.req_type), .start_pos(req.start_pos), .end_pos(req.end_pos),
		.limit_value(req.limit_value), .query_pos(req.query_pos),
		.cmd, .sts,
		.found(rsp.found), .limit_out(rsp.limit_out),
		.overflow(rsp.overflow), .entry_count(rsp.entry_count)
	);
endmodule

// ===== design/slit_ctrl.sv =====
// ----------------------------------------------------------------------------
// slit_ctrl: sequencer of the interval table
// Steps lookup scans, merge walks, the sort and the write-back.
// ----------------------------------------------------------------------------
module slit_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  slit_pkg::sts_t sts,
	output slit_pkg::cmd_t cmd
);
	import slit_pkg::*;

	state_t state_q, state_d;
	logic   ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin)
				ov_q <= 1'b1;
			else if (ov_q && out_ready)
				ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// first cycle after load chooses the path
				if (sts.req_type == REQ_INSERT) begin
					state_d = ST_WALK;
				end else if (sts.idx_last || sts.look_hit) begin
					state_d = ST_DONE;
				end else begin
					cmd.look_step = 1'b1;
				end
			end
			ST_WALK: begin
				if (sts.idx_last) begin
					state_d = ST_TAIL;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_TAIL: begin
				cmd.tail = 1'b1;
				state_d = ST_SORT;
			end
			ST_SORT: begin
				if (sts.over) begin
					state_d = ST_DONE;
				end else if (sts.sort_done) begin
					state_d = ST_COPY;
				end else begin
					cmd.sort_step = 1'b1;
				end
			end
			ST_COPY: begin
				if (sts.copy_done) begin
					cmd.commit = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.copy_step = 1'b1;
				end
			end
			ST_DONE: begin
				// hold the finished word until the result register is free
				if (!ov_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== design/slit_dp.sv =====
// ----------------------------------------------------------------------------
// slit_dp: datapath of the interval table
// Table memory, piece scratch memory, merge walk, insertion sort, result.
// ----------------------------------------------------------------------------
module slit_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_type,
	input  logic signed [31:0]      start_pos,
	input  logic signed [31:0]      end_pos,
	input  logic        [15:0]      limit_value,
	input  logic signed [31:0]      query_pos,
	input  slit_pkg::cmd_t          cmd,
	output slit_pkg::sts_t          sts,
	output logic                    found,
	output logic        [15:0]      limit_out,
	output logic                    overflow,
	output logic        [5:0]       entry_count
);
	import slit_pkg::*;

	typedef struct packed {
		logic signed [PosW-1:0] lo;
		logic signed [PosW-1:0] hi;
		logic        [LimW-1:0] lim;
	} piece_t;

	// Table and scratch are held as flop arrays; the walk reads one table entry
	// per cycle at idx, the sort compares/swaps two adjacent scratch slots.
	// Scratch keeps only the first MaxIntervals pieces; any further piece is
	// just counted, since the insert is rejected then.
	piece_t tbl_q [MaxIntervals];
	piece_t scr_q [MaxIntervals];

	logic                   rt_q;
	logic signed [PosW-1:0] s_q, e_q, qp_q;
	logic        [LimW-1:0] lim_q;
	logic        [CntW-1:0] cnt_q;
	logic        [CntW-1:0] idx_q;
	logic        [PcW-1:0]  pn_q;
	logic        [PcW-1:0]  si_q, sj_q;
	logic                   hit_q;
	logic        [LimW-1:0] hl_q;

	piece_t cur;
	assign cur = tbl_q[idx_q[IdxW-1:0]];

	// pieces from one walk step, up to three
	piece_t p [3];
	logic   pv [3];
	logic   ovl;
	logic [LimW-1:0] mn;
	logic signed [PosW-1:0] e_nx;
	always_comb begin
		ovl = !(s_q >= cur.hi || e_q <= cur.lo);
		mn = (cur.lim < lim_q) ? cur.lim : lim_q;
		for (int k = 0; k < 3; k++) p[k] = '0;
		if (!ovl) begin
			p[0] = '{cur.lo, cur.hi, cur.lim};
		end else if (s_q >= cur.lo) begin
			p[0] = '{cur.lo, s_q, cur.lim};
			if (e_q <= cur.hi) begin
				p[1] = '{s_q, e_q, mn};
				p[2] = '{e_q, cur.hi, cur.lim};
			end else begin
				p[1] = '{s_q, cur.hi, mn};
			end
		end else begin
			p[0] = '{s_q, cur.lo, lim_q};
			if (e_q <= cur.hi) begin
				p[1] = '{cur.lo, e_q, mn};
				p[2] = '{e_q, cur.hi, cur.lim};
			end else begin
				p[1] = '{cur.lo, cur.hi, mn};
			end
		end
		for (int k = 0; k < 3; k++) pv[k] = p[k].lo < p[k].hi;
		e_nx = (cur.hi > e_q) ? cur.hi : e_q;
	end

	// sort step: compare scr[sj-1] with scr[sj]
	piece_t sa, sb;
	logic   swap;
	assign sa = scr_q[IdxW'(sj_q - PcW'(1))];
	assign sb = scr_q[sj_q[IdxW-1:0]];
	always_comb begin
		if (sb.lo != sa.lo) swap = sb.lo < sa.lo;
		else if (sb.hi != sa.hi) swap = sb.hi < sa.hi;
		else swap = sb.lim < sa.lim;
	end

	logic look_hit;
	assign look_hit = qp_q >= cur.lo && qp_q <= cur.hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			pn_q <= '0;
			si_q <= '0;
			sj_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				pn_q <= '0;
				hit_q <= 1'b0;
				si_q <= PcW'(1);
				sj_q <= PcW'(1);
			end
			if (cmd.look_step) begin
				if (look_hit) hit_q <= 1'b1;
				else idx_q <= idx_q + CntW'(1);
			end
			if (cmd.walk_step) begin
				idx_q <= idx_q + CntW'(1);
				pn_q <= pn_q + PcW'(pv[0]) + PcW'(pv[1]) + PcW'(pv[2]);
			end
			if (cmd.tail && s_q < e_q)
				pn_q <= pn_q + PcW'(1);
			if (cmd.sort_step) begin
				if (sj_q != '0 && si_q < pn_q && swap) begin
					sj_q <= sj_q - PcW'(1);
				end else begin
					si_q <= si_q + PcW'(1);
					sj_q <= si_q + PcW'(1);
				end
			end
			if (cmd.tail)
				idx_q <= '0;
			if (cmd.copy_step)
				idx_q <= idx_q + CntW'(1);
			if (cmd.commit)
				cnt_q <= CntW'(pn_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rt_q <= req_type;
			s_q <= start_pos;
			e_q <= end_pos;
			lim_q <= limit_value;
			qp_q <= query_pos;
		end
		if (cmd.look_step && look_hit)
			hl_q <= cur.lim;
		if (cmd.walk_step) begin
			logic [PcW-1:0] w;
			w = pn_q;
			for (int k = 0; k < 3; k++) begin
				if (pv[k] && w < PcW'(MaxIntervals)) begin
					scr_q[w[IdxW-1:0]] <= p[k];
					w = w + PcW'(1);
				end
			end
			if (ovl) begin
				s_q <= cur.hi;
				e_q <= e_nx;
			end
		end
		if (cmd.tail && s_q < e_q && pn_q < PcW'(MaxIntervals))
			scr_q[pn_q[IdxW-1:0]] <= '{s_q, e_q, lim_q};
		if (cmd.sort_step && sj_q != '0 && si_q < pn_q && swap) begin
			scr_q[IdxW'(sj_q - PcW'(1))] <= sb;
			scr_q[sj_q[IdxW-1:0]] <= sa;
		end
		if (cmd.copy_step)
			tbl_q[idx_q[IdxW-1:0]] <= scr_q[idx_q[IdxW-1:0]];
		if (cmd.fin) begin
			found <= rt_q == REQ_LOOKUP ? hit_q : !(pn_q > PcW'(MaxIntervals));
			limit_out <= (rt_q == REQ_LOOKUP && hit_q) ? hl_q : '0;
			overflow <= rt_q == REQ_INSERT && pn_q > PcW'(MaxIntervals);
			entry_count <= OutCntW'(cnt_q);
		end
	end

	assign sts.req_type = rt_q;
	assign sts.idx_last = idx_q == cnt_q;
	assign sts.look_hit = hit_q;
	assign sts.sort_done = si_q >= pn_q;
	assign sts.copy_done = PcW'(idx_q) == pn_q;
	assign sts.over = pn_q > PcW'(MaxIntervals);
endmodule

// ===== design/slit_chk.sv =====
// ----------------------------------------------------------------------------
// slit_chk: port checks of the interval table
// Result word rules seen at the top level ports.
// ----------------------------------------------------------------------------
module slit_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_found,
	input logic [15:0] rsp_limit_out,
	input logic       rsp_overflow,
	input logic [5:0] rsp_entry_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_limit_out))
		else $error("result word dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_found && rsp_overflow))
		else $error("found and overflow together");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_count <= 6'd32)
		else $error("count beyond capacity");
	a_lim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_overflow |-> rsp_limit_out == 16'd0)
		else $error("limit on rejected insert");
endmodule

bind speed_limit_interval_table slit_chk u_chk (
	.clk, .arst_n,
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_found(rsp.found),
	.rsp_limit_out(rsp.limit_out), .rsp_overflow(rsp.overflow),
	.rsp_entry_count(rsp.entry_count)
);
